/* sv/lavm_pkg.sv */
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types, formats and rounding helpers of the look-at view matrix unit.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int AXIS_FRAC_BITS = 30;              // axis format Q.F
  localparam int NORM_MSB       = 29;              // block-scaled max sits at this bit
  localparam int MAG_W          = 63;              // |input| <= 2^62
  localparam int SHM_W          = NORM_MSB + 1;    // scaled magnitude width
  localparam int SQ_W           = 2 * SHM_W + 2;   // sum of three squares
  localparam int ROOT_W         = SHM_W + 1;       // floor(sqrt(sum))
  localparam int QUO_W          = AXIS_FRAC_BITS + 1;
  localparam int DIV_W          = 64;
  // abs, max, msb, shift, square, sum, root bits, quotient bits, sign
  localparam int NORM_LAT       = 6 + ROOT_W + QUO_W + 1;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [63:0] wide_t;
  typedef logic [1:0]         row_t;

  localparam row_t ROW_U = 2'd0;
  localparam row_t ROW_V = 2'd1;
  localparam row_t ROW_W = 2'd2;

  localparam wide_t AXIS_ONE = 64'sd1 <<< AXIS_FRAC_BITS;
  localparam wide_t OFF_MAX  = 64'sd2147483647;
  localparam wide_t OFF_MIN  = -64'sd2147483648;

  // finished axes of one request, handed to the row sequencer
  typedef struct packed {
    logic           ok;
    coord_t [2:0]   u;
    coord_t [2:0]   v;
    coord_t [2:0]   w;
    coord_t [2:0]   pos;
  } frame_t;

  // round half away from zero by AXIS_FRAC_BITS
  function automatic wide_t round_axis(wide_t x);
    logic [63:0] mag;
    logic [63:0] q;
    mag = x[63] ? 64'(-x) : 64'(x);
    q   = (mag + (64'd1 << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS;
    return x[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

/* sv/lavm_normalize.sv */
// ----------------------------------------------------------------------------
// lavm_normalize
// Pipelined unit-vector unit: block scale, sum of squares, bit-per-stage
// square root, then three bit-per-stage dividers.
// ----------------------------------------------------------------------------
module lavm_normalize (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vec_valid,
  input  lavm_pkg::wide_t [2:0]       vec_in,
  output logic                        unit_valid,
  output logic                        unit_ok,
  output lavm_pkg::coord_t [2:0]      unit_out
);
  import lavm_pkg::*;

  function automatic logic [5:0] msb_pos(logic [MAG_W-1:0] x);
    logic [5:0] p;
    p = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (x[b]) p = 6'(b);
    end
    return p;
  endfunction

  // front stages
  logic             s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic [MAG_W-1:0] s1_mag_r [3];
  logic [MAG_W-1:0] s2_mag_r [3];
  logic [MAG_W-1:0] s3_mag_r [3];
  logic [2:0]       s1_neg_r, s2_neg_r, s3_neg_r, s4_neg_r, s5_neg_r, s6_neg_r;
  logic [MAG_W-1:0] s2_max_r;
  logic [5:0]       s3_msb_r;
  logic             s3_nz_r, s4_nz_r, s5_nz_r, s6_nz_r;
  logic [SHM_W-1:0] s4_sh_r [3];
  logic [SHM_W-1:0] s5_sh_r [3];
  logic [SHM_W-1:0] s6_sh_r [3];
  logic [2*SHM_W-1:0] s5_sq_r [3];
  logic [SQ_W-1:0]  s6_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0;
      s4_v_r <= 1'b0; s5_v_r <= 1'b0; s6_v_r <= 1'b0;
    end else begin
      s1_v_r <= vec_valid; s2_v_r <= s1_v_r; s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;    s5_v_r <= s4_v_r; s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_neg_r[i] <= vec_in[i][63];
      s1_mag_r[i] <= vec_in[i][63] ? MAG_W'(-$signed(vec_in[i])) : MAG_W'(vec_in[i]);
      s2_mag_r[i] <= s1_mag_r[i];
      s3_mag_r[i] <= s2_mag_r[i];
      if (s3_msb_r >= 6'(NORM_MSB))
        s4_sh_r[i] <= SHM_W'(s3_mag_r[i] >> (s3_msb_r - 6'(NORM_MSB)));
      else
        s4_sh_r[i] <= SHM_W'(s3_mag_r[i] << (6'(NORM_MSB) - s3_msb_r));
      s5_sh_r[i] <= s4_sh_r[i];
      s5_sq_r[i] <= s4_sh_r[i] * s4_sh_r[i];
      s6_sh_r[i] <= s5_sh_r[i];
    end
    s2_max_r <= (s1_mag_r[0] >= s1_mag_r[1]) ?
                ((s1_mag_r[0] >= s1_mag_r[2]) ? s1_mag_r[0] : s1_mag_r[2]) :
                ((s1_mag_r[1] >= s1_mag_r[2]) ? s1_mag_r[1] : s1_mag_r[2]);
    s3_msb_r <= msb_pos(s2_max_r);
    s3_nz_r  <= (s2_max_r != '0);
    s4_nz_r  <= s3_nz_r;  s5_nz_r  <= s4_nz_r;  s6_nz_r  <= s5_nz_r;
    s2_neg_r <= s1_neg_r; s3_neg_r <= s2_neg_r; s4_neg_r <= s3_neg_r;
    s5_neg_r <= s4_neg_r; s6_neg_r <= s5_neg_r;
    s6_sum_r <= SQ_W'(s5_sq_r[0]) + SQ_W'(s5_sq_r[1]) + SQ_W'(s5_sq_r[2]);
  end

  // square root, one result bit per stage
  logic              sq_v_r    [ROOT_W];
  logic [SQ_W-1:0]   sq_rem_r  [ROOT_W];
  logic [ROOT_W-1:0] sq_root_r [ROOT_W];
  logic [SHM_W-1:0]  sq_mag_r  [ROOT_W][3];
  logic [2:0]        sq_neg_r  [ROOT_W];
  logic              sq_nz_r   [ROOT_W];
  logic [SQ_W-1:0]   sq_rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] sq_root_nxt [ROOT_W];
  logic [SQ_W-1:0]   sq_rem_in   [ROOT_W];
  logic [ROOT_W-1:0] sq_root_in  [ROOT_W];

  always_comb begin
    sq_rem_in[0]  = s6_sum_r;
    sq_root_in[0] = '0;
    for (int k = 1; k < ROOT_W; k++) begin
      sq_rem_in[k]  = sq_rem_r[k-1];
      sq_root_in[k] = sq_root_r[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      logic [63:0] trial;
      trial = (64'(sq_root_in[k]) << (ROOT_W - k)) | (64'd1 << (2 * (ROOT_W - 1 - k)));
      if (64'(sq_rem_in[k]) >= trial) begin
        sq_rem_nxt[k]  = sq_rem_in[k] - SQ_W'(trial);
        sq_root_nxt[k] = sq_root_in[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
      end else begin
        sq_rem_nxt[k]  = sq_rem_in[k];
        sq_root_nxt[k] = sq_root_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_W; k++) sq_v_r[k] <= 1'b0;
    end else begin
      sq_v_r[0] <= s6_v_r;
      for (int k = 1; k < ROOT_W; k++) sq_v_r[k] <= sq_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_W; k++) begin
      sq_rem_r[k]  <= sq_rem_nxt[k];
      sq_root_r[k] <= sq_root_nxt[k];
    end
    sq_neg_r[0] <= s6_neg_r;
    sq_nz_r[0]  <= s6_nz_r;
    for (int i = 0; i < 3; i++) sq_mag_r[0][i] <= s6_sh_r[i];
    for (int k = 1; k < ROOT_W; k++) begin
      sq_neg_r[k] <= sq_neg_r[k-1];
      sq_nz_r[k]  <= sq_nz_r[k-1];
      for (int i = 0; i < 3; i++) sq_mag_r[k][i] <= sq_mag_r[k-1][i];
    end
  end

  // three restoring dividers, one quotient bit per stage
  logic              dv_v_r    [QUO_W];
  logic [DIV_W-1:0]  dv_rem_r  [QUO_W][3];
  logic [QUO_W-1:0]  dv_quo_r  [QUO_W][3];
  logic [ROOT_W-1:0] dv_root_r [QUO_W];
  logic [2:0]        dv_neg_r  [QUO_W];
  logic              dv_nz_r   [QUO_W];
  logic [DIV_W-1:0]  dv_rem_in  [QUO_W][3];
  logic [QUO_W-1:0]  dv_quo_in  [QUO_W][3];
  logic [ROOT_W-1:0] dv_root_in [QUO_W];
  logic [DIV_W-1:0]  dv_rem_nxt [QUO_W][3];
  logic [QUO_W-1:0]  dv_quo_nxt [QUO_W][3];

  always_comb begin
    dv_root_in[0] = sq_root_r[ROOT_W-1];
    for (int i = 0; i < 3; i++) begin
      dv_rem_in[0][i] = (DIV_W'(sq_mag_r[ROOT_W-1][i]) << AXIS_FRAC_BITS) +
                        DIV_W'(sq_root_r[ROOT_W-1] >> 1);
      dv_quo_in[0][i] = '0;
    end
    for (int k = 1; k < QUO_W; k++) begin
      dv_root_in[k] = dv_root_r[k-1];
      for (int i = 0; i < 3; i++) begin
        dv_rem_in[k][i] = dv_rem_r[k-1][i];
        dv_quo_in[k][i] = dv_quo_r[k-1][i];
      end
    end
    for (int k = 0; k < QUO_W; k++) begin
      for (int i = 0; i < 3; i++) begin
        logic [DIV_W-1:0] dsh;
        dsh = DIV_W'(dv_root_in[k]) << (QUO_W - 1 - k);
        if (dv_rem_in[k][i] >= dsh) begin
          dv_rem_nxt[k][i] = dv_rem_in[k][i] - dsh;
          dv_quo_nxt[k][i] = dv_quo_in[k][i] | (QUO_W'(1) << (QUO_W - 1 - k));
        end else begin
          dv_rem_nxt[k][i] = dv_rem_in[k][i];
          dv_quo_nxt[k][i] = dv_quo_in[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUO_W; k++) dv_v_r[k] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[ROOT_W-1];
      for (int k = 1; k < QUO_W; k++) dv_v_r[k] <= dv_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      dv_root_r[k] <= dv_root_in[k];
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[k][i] <= dv_rem_nxt[k][i];
        dv_quo_r[k][i] <= dv_quo_nxt[k][i];
      end
    end
    dv_neg_r[0] <= sq_neg_r[ROOT_W-1];
    dv_nz_r[0]  <= sq_nz_r[ROOT_W-1];
    for (int k = 1; k < QUO_W; k++) begin
      dv_neg_r[k] <= dv_neg_r[k-1];
      dv_nz_r[k]  <= dv_nz_r[k-1];
    end
  end

  // sign restore
  logic            out_v_r;
  logic            out_ok_r;
  coord_t [2:0]    out_unit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else        out_v_r <= dv_v_r[QUO_W-1];
  end

  always_ff @(posedge clk) begin
    out_ok_r <= dv_nz_r[QUO_W-1];
    for (int i = 0; i < 3; i++) begin
      out_unit_r[i] <= dv_neg_r[QUO_W-1][i] ? -$signed(32'(dv_quo_r[QUO_W-1][i]))
                                            :  $signed(32'(dv_quo_r[QUO_W-1][i]));
    end
  end

  assign unit_valid = out_v_r;
  assign unit_ok    = out_ok_r;
  assign unit_out   = out_unit_r;

endmodule

/* sv/lavm_row_out.sv */
// ----------------------------------------------------------------------------
// lavm_row_out
// Row sequencer: holds one frame, issues u, v, w rows in turn and
// forms each saturated offset in a short dot-product pipeline.
// ----------------------------------------------------------------------------
module lavm_row_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frame_valid,
  input  lavm_pkg::frame_t  frame,
  output logic              out_strobe,
  output logic [1:0]        out_row_index,
  output logic signed [31:0] out_axis_x,
  output logic signed [31:0] out_axis_y,
  output logic signed [31:0] out_axis_z,
  output logic signed [31:0] out_offset,
  output logic              out_degenerate,
  output logic              out_last_row
);
  import lavm_pkg::*;

  frame_t hold_r;
  logic   act_r;
  row_t   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= ROW_U;
    end else if (frame_valid) begin
      act_r <= 1'b1;
      cnt_r <= ROW_U;
    end else if (act_r) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == ROW_W) act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid) hold_r <= frame;
  end

  coord_t [2:0] sel_axis;
  always_comb begin
    case (cnt_r)
      ROW_U:   sel_axis = hold_r.u;
      ROW_V:   sel_axis = hold_r.v;
      default: sel_axis = hold_r.w;
    endcase
  end

  // R1 products, R2 dot, R3 round and saturate
  logic         r1_v_r, r2_v_r, r3_v_r;
  row_t         r1_row_r, r2_row_r, r3_row_r;
  logic         r1_ok_r, r2_ok_r, r3_ok_r;
  coord_t [2:0] r1_axis_r, r2_axis_r, r3_axis_r;
  wide_t        r1_prod_r [3];
  wide_t        r2_dot_r;
  coord_t       r3_off_r;
  wide_t        off_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0; r2_v_r <= 1'b0; r3_v_r <= 1'b0;
    end else begin
      r1_v_r <= act_r; r2_v_r <= r1_v_r; r3_v_r <= r2_v_r;
    end
  end

  always_comb begin
    off_nxt = -round_axis(r2_dot_r);
    if (off_nxt > OFF_MAX)      off_nxt = OFF_MAX;
    else if (off_nxt < OFF_MIN) off_nxt = OFF_MIN;
  end

  always_ff @(posedge clk) begin
    r1_row_r  <= cnt_r;
    r1_ok_r   <= hold_r.ok;
    r1_axis_r <= sel_axis;
    for (int i = 0; i < 3; i++) r1_prod_r[i] <= $signed(sel_axis[i]) * $signed(hold_r.pos[i]);
    r2_row_r  <= r1_row_r;
    r2_ok_r   <= r1_ok_r;
    r2_axis_r <= r1_axis_r;
    r2_dot_r  <= r1_prod_r[0] + r1_prod_r[1] + r1_prod_r[2];
    r3_row_r  <= r2_row_r;
    r3_ok_r   <= r2_ok_r;
    r3_axis_r <= r2_ok_r ? r2_axis_r : '0;
    r3_off_r  <= r2_ok_r ? 32'(off_nxt) : '0;
  end

  assign out_strobe     = r3_v_r;
  assign out_row_index  = r3_row_r;
  assign out_axis_x     = r3_axis_r[0];
  assign out_axis_y     = r3_axis_r[1];
  assign out_axis_z     = r3_axis_r[2];
  assign out_offset     = r3_off_r;
  assign out_degenerate = !r3_ok_r;
  assign out_last_row   = (r3_row_r == ROW_W);

endmodule

/* sv/look_at_view_matrix_unit.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Fixed-point look-at camera: builds u, v, w axes and their offsets and
// emits them as three rows per request.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | start & !busy          | in_opcode, in_pos_*, in_aim_*, in_up_*
//  result   | out_strobe             | out_row_index, out_axis_*, out_offset,
//           |                        | out_degenerate, out_last_row
//
//  After an accepted request busy stays high and a new request waits; the
//  spacing matches the three result rows each request produces.
//  The first row follows both normalizers in turn
//  (31 root stages and 31 quotient stages each).
//  Reset (rst_n low, synchronous) drops all requests in flight.
//  The receiver cannot stall; the three rows of a request leave back to back.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_aim_x,
  input  logic signed [31:0] in_aim_y,
  input  logic signed [31:0] in_aim_z,
  input  logic signed [31:0] in_up_x,
  input  logic signed [31:0] in_up_y,
  input  logic signed [31:0] in_up_z,
  output logic               out_strobe,
  output logic [1:0]         out_row_index,
  output logic signed [31:0] out_axis_x,
  output logic signed [31:0] out_axis_y,
  output logic signed [31:0] out_axis_z,
  output logic signed [31:0] out_offset,
  output logic               out_degenerate,
  output logic               out_last_row
);
  import lavm_pkg::*;

  // request spacing: a new request waits while busy is high
  logic [1:0] gap_r;
  logic       accept;
  assign busy   = (gap_r != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n)       gap_r <= 2'd0;
    else if (accept)  gap_r <= 2'd2;
    else if (busy)    gap_r <= gap_r - 2'd1;
  end

  // T0: forward direction, target difference at full width if in_opcode, else aim
  logic         t0_v_r;
  wide_t [2:0]  t0_d_r;
  coord_t [2:0] t0_pos_r, t0_up_r;
  coord_t [2:0] in_pos, in_aim, in_up;

  assign in_pos = {in_pos_z, in_pos_y, in_pos_x};
  assign in_aim = {in_aim_z, in_aim_y, in_aim_x};
  assign in_up  = {in_up_z,  in_up_y,  in_up_x};

  always_ff @(posedge clk) begin
    if (!rst_n) t0_v_r <= 1'b0;
    else        t0_v_r <= accept;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t0_d_r[i] <= in_opcode ? (wide_t'($signed(in_aim[i])) - wide_t'($signed(in_pos[i])))
                             :  wide_t'($signed(in_aim[i]));
    end
    t0_pos_r <= in_pos;
    t0_up_r  <= in_up;
  end

  // w = unit(direction)
  logic         wn_v, wn_ok;
  coord_t [2:0] wn_unit;

  lavm_normalize u_norm_w (
    .clk        (clk),
    .rst_n      (rst_n),
    .vec_valid  (t0_v_r),
    .vec_in     (t0_d_r),
    .unit_valid (wn_v),
    .unit_ok    (wn_ok),
    .unit_out   (wn_unit)
  );

  // position and up ride alongside the w normalizer
  coord_t [2:0] dw_pos_r [NORM_LAT];
  coord_t [2:0] dw_up_r  [NORM_LAT];

  always_ff @(posedge clk) begin
    dw_pos_r[0] <= t0_pos_r;
    dw_up_r[0]  <= t0_up_r;
    for (int k = 1; k < NORM_LAT; k++) begin
      dw_pos_r[k] <= dw_pos_r[k-1];
      dw_up_r[k]  <= dw_up_r[k-1];
    end
  end

  // C1 products, C2 cross(w, up)
  logic         c1_v_r, c2_v_r;
  wide_t        c1_p_r [6];
  coord_t [2:0] c1_w_r, c1_pos_r, c2_w_r, c2_pos_r;
  logic         c1_ok_r, c2_ok_r;
  wide_t [2:0]  c2_c_r;
  coord_t [2:0] up_d;

  assign up_d = dw_up_r[NORM_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0; c2_v_r <= 1'b0;
    end else begin
      c1_v_r <= wn_v; c2_v_r <= c1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_p_r[0] <= $signed(wn_unit[1]) * $signed(up_d[2]);
    c1_p_r[1] <= $signed(wn_unit[2]) * $signed(up_d[1]);
    c1_p_r[2] <= $signed(wn_unit[2]) * $signed(up_d[0]);
    c1_p_r[3] <= $signed(wn_unit[0]) * $signed(up_d[2]);
    c1_p_r[4] <= $signed(wn_unit[0]) * $signed(up_d[1]);
    c1_p_r[5] <= $signed(wn_unit[1]) * $signed(up_d[0]);
    c1_w_r    <= wn_unit;
    c1_pos_r  <= dw_pos_r[NORM_LAT-1];
    c1_ok_r   <= wn_ok;
    c2_c_r[0] <= c1_p_r[0] - c1_p_r[1];
    c2_c_r[1] <= c1_p_r[2] - c1_p_r[3];
    c2_c_r[2] <= c1_p_r[4] - c1_p_r[5];
    c2_w_r    <= c1_w_r;
    c2_pos_r  <= c1_pos_r;
    c2_ok_r   <= c1_ok_r;
  end

  // u = unit(cross(w, up))
  logic         un_v, un_ok;
  coord_t [2:0] un_unit;

  lavm_normalize u_norm_u (
    .clk        (clk),
    .rst_n      (rst_n),
    .vec_valid  (c2_v_r),
    .vec_in     (c2_c_r),
    .unit_valid (un_v),
    .unit_ok    (un_ok),
    .unit_out   (un_unit)
  );

  coord_t [2:0] du_w_r   [NORM_LAT];
  coord_t [2:0] du_pos_r [NORM_LAT];
  logic         du_ok_r  [NORM_LAT];

  always_ff @(posedge clk) begin
    du_w_r[0]   <= c2_w_r;
    du_pos_r[0] <= c2_pos_r;
    du_ok_r[0]  <= c2_ok_r;
    for (int k = 1; k < NORM_LAT; k++) begin
      du_w_r[k]   <= du_w_r[k-1];
      du_pos_r[k] <= du_pos_r[k-1];
      du_ok_r[k]  <= du_ok_r[k-1];
    end
  end

  // V1 products, V2 cross(w, u), V3 round and clamp to +-1.0
  logic         v1_v_r, v2_v_r, v3_v_r;
  wide_t        v1_p_r [6];
  wide_t [2:0]  v2_d_r;
  frame_t       v1_f_r, v2_f_r, v3_f_r;
  frame_t       v3_f_nxt;
  coord_t [2:0] wd;
  wide_t        vr [3];

  assign wd = du_w_r[NORM_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_v_r <= 1'b0; v2_v_r <= 1'b0; v3_v_r <= 1'b0;
    end else begin
      v1_v_r <= un_v; v2_v_r <= v1_v_r; v3_v_r <= v2_v_r;
    end
  end

  always_comb begin
    v3_f_nxt = v2_f_r;
    for (int i = 0; i < 3; i++) begin
      vr[i] = round_axis(v2_d_r[i]);
      if (vr[i] > AXIS_ONE)       vr[i] = AXIS_ONE;
      else if (vr[i] < -AXIS_ONE) vr[i] = -AXIS_ONE;
      v3_f_nxt.v[i] = 32'(vr[i]);
    end
  end

  always_ff @(posedge clk) begin
    v1_p_r[0] <= $signed(wd[1]) * $signed(un_unit[2]);
    v1_p_r[1] <= $signed(wd[2]) * $signed(un_unit[1]);
    v1_p_r[2] <= $signed(wd[2]) * $signed(un_unit[0]);
    v1_p_r[3] <= $signed(wd[0]) * $signed(un_unit[2]);
    v1_p_r[4] <= $signed(wd[0]) * $signed(un_unit[1]);
    v1_p_r[5] <= $signed(wd[1]) * $signed(un_unit[0]);
    v1_f_r.ok  <= du_ok_r[NORM_LAT-1] && un_ok;
    v1_f_r.u   <= un_unit;
    v1_f_r.v   <= '0;
    v1_f_r.w   <= wd;
    v1_f_r.pos <= du_pos_r[NORM_LAT-1];
    v2_d_r[0] <= v1_p_r[0] - v1_p_r[1];
    v2_d_r[1] <= v1_p_r[2] - v1_p_r[3];
    v2_d_r[2] <= v1_p_r[4] - v1_p_r[5];
    v2_f_r    <= v1_f_r;
    v3_f_r    <= v3_f_nxt;
  end

  // three rows per request
  lavm_row_out u_rows (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_valid    (v3_v_r),
    .frame          (v3_f_r),
    .out_strobe     (out_strobe),
    .out_row_index  (out_row_index),
    .out_axis_x     (out_axis_x),
    .out_axis_y     (out_axis_y),
    .out_axis_z     (out_axis_z),
    .out_offset     (out_offset),
    .out_degenerate (out_degenerate),
    .out_last_row   (out_last_row)
  );

endmodule

/* sv/lavm_checker.sv */
// ----------------------------------------------------------------------------
// lavm_checker
// Port-level checks of the look-at view matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module lavm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic [1:0]         out_row_index,
  input logic signed [31:0] out_axis_x,
  input logic signed [31:0] out_axis_y,
  input logic signed [31:0] out_axis_z,
  input logic signed [31:0] out_offset,
  input logic               out_degenerate,
  input logic               out_last_row
);
  import lavm_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe && !busy)
    else $error("strobe or busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted without spacing");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_row_index == ROW_U |=> out_strobe && out_row_index == ROW_V)
    else $error("row v did not follow row u");

  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_last_row == (out_row_index == ROW_W)))
    else $error("last_row mismatch");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_degenerate |->
      out_axis_x == 0 && out_axis_y == 0 && out_axis_z == 0 && out_offset == 0)
    else $error("degenerate row not zero");

endmodule

bind look_at_view_matrix_unit lavm_checker u_lavm_checker (.*);
